// ===== hdl/irpwd_pkg.sv =====
// Shared types and constants for the IR pulse-width decoder.
// Used by irpwd_div and ir_pulse_width_decoder_core; no dependencies.
package irpwd_pkg;

    localparam int PERIOD_W = 16;
    localparam int UNIT_W   = 16;
    localparam int TMO_W    = 8;
    localparam int QUO_W    = 8;
    localparam int SHIFT_W  = 16;
    localparam int COUNT_W  = 8;
    localparam int GAP_W    = 8;
    localparam int DIV_STEPS = PERIOD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [QUO_W-1:0]   Q_ZERO_BIT = 8'd1;
    localparam logic [QUO_W-1:0]   Q_ONE_BIT  = 8'd2;
    localparam logic [QUO_W-1:0]   Q_SYNC     = 8'd13;
    localparam logic [QUO_W-1:0]   Q_LOW      = 8'd8;
    localparam logic [QUO_W-1:0]   Q_HIGH     = 8'd100;
    localparam logic [COUNT_W-1:0] FRAME_BITS = 8'd16;
    localparam logic [GAP_W-1:0]   GAP_MAX    = 8'hFF;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd32;
    localparam logic [TMO_W-1:0]  TMO_RESET  = 8'd56;

    // register indexes (paddr[2])
    localparam logic REG_UNIT    = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    typedef struct packed {
        logic                start;
        logic [PERIOD_W-1:0] dividend;
        logic [UNIT_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage

// ===== hdl/irpwd_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on irpwd_pkg. A zero divisor gives an all-ones quotient.
module irpwd_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  irpwd_pkg::div_req_t req,
    output irpwd_pkg::div_rsp_t rsp
);

    logic [irpwd_pkg::UNIT_W-1:0]   rem_reg, rem_next;
    logic [irpwd_pkg::PERIOD_W-1:0] quo_reg, quo_next;
    logic [irpwd_pkg::UNIT_W-1:0]   dsr_reg;
    logic [irpwd_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [irpwd_pkg::UNIT_W:0]     trial;
    logic [irpwd_pkg::UNIT_W:0]     diff;

    // partial remainder with next dividend bit shifted in
    assign trial = {rem_reg, quo_reg[irpwd_pkg::PERIOD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[irpwd_pkg::UNIT_W])
            begin
                rem_next = diff[irpwd_pkg::UNIT_W-1:0];
                quo_next = {quo_reg[irpwd_pkg::PERIOD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[irpwd_pkg::UNIT_W-1:0];
                quo_next = {quo_reg[irpwd_pkg::PERIOD_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == irpwd_pkg::STEP_W'(irpwd_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
        begin
            dsr_reg <= req.divisor;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg[irpwd_pkg::QUO_W-1:0];

endmodule

// ===== hdl/ir_pulse_width_decoder_core.sv =====
// Top level of the IR pulse-width decoder: stream ports, APB registers,
// frame state and output register. Depends on irpwd_pkg and irpwd_div.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser = cmd, tdata = period
//  m_*     | out | m_tvalid/m_tready  | tdata = shift, count, code, latched
//  apb     | in  | psel/penable/pready| unit_ticks @0x0, timeout_ticks @0x4
//
// Capture transfers are accepted, run the divider steps (one quotient bit
// each, bit-serial), then the quotient is collected and the update is made.
// Tick transfers are accepted and then updated; a new item is taken only in idle.
// Reset (rst_n low, asynchronous) clears frame state and restores defaults.
// A stalled m_tready holds the update step; the next item is still taken
// while a finished result waits in the output register.
module ir_pulse_width_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] period
    input  logic        s_tuser,   // [0] cmd (0 capture, 1 tick)
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] shift_data, [23:16] bit_count,
                                   // [39:24] user_code, [40] code_latched
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0] state_reg, state_next;

    // configuration
    logic [irpwd_pkg::UNIT_W-1:0] unit_reg;
    logic [irpwd_pkg::TMO_W-1:0]  tmo_reg;
    logic                         cfg_wr;

    // frame state
    logic [irpwd_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic [irpwd_pkg::COUNT_W-1:0] bits_reg, bits_next;
    logic [irpwd_pkg::GAP_W-1:0]   gap_reg, gap_next;
    logic [irpwd_pkg::SHIFT_W-1:0] code_reg, code_next;
    logic                          latch;

    // item in flight
    logic                        cmd_reg;
    logic [irpwd_pkg::QUO_W-1:0] q_reg;

    // output register
    logic        out_valid_reg;
    logic [40:0] out_data_reg;
    logic        out_load;

    irpwd_pkg::div_req_t div_req;
    irpwd_pkg::div_rsp_t div_rsp;

    logic accept;
    logic is_bit;
    logic abandon;
    logic [irpwd_pkg::GAP_W-1:0] gap_inc;

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr[2] == irpwd_pkg::REG_UNIT)
        begin
            prdata = {16'd0, unit_reg};
        end
        else
        begin
            prdata = {24'd0, tmo_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= irpwd_pkg::UNIT_RESET;
            tmo_reg  <= irpwd_pkg::TMO_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == irpwd_pkg::REG_UNIT)
            begin
                unit_reg <= pwdata[irpwd_pkg::UNIT_W-1:0];
            end
            else
            begin
                tmo_reg <= pwdata[irpwd_pkg::TMO_W-1:0];
            end
        end
    end

    // ---------------- control ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign div_req.start    = accept && !s_tuser;
    assign div_req.dividend = s_tdata;
    assign div_req.divisor  = unit_reg;

    irpwd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // result slot is free when empty or draining this cycle
    assign out_load = (state_reg == ST_APPLY) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = s_tuser ? ST_APPLY : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_tuser;
        end
        if (div_rsp.done)
        begin
            q_reg <= div_rsp.quo;
        end
    end

    // ---------------- frame update ----------------
    assign is_bit  = (q_reg == irpwd_pkg::Q_ZERO_BIT) || (q_reg == irpwd_pkg::Q_ONE_BIT);
    assign abandon = (q_reg == irpwd_pkg::Q_SYNC) || (q_reg < irpwd_pkg::Q_LOW)
                     || (q_reg > irpwd_pkg::Q_HIGH);
    assign gap_inc = (gap_reg == irpwd_pkg::GAP_MAX) ? gap_reg : gap_reg + 1'b1;

    always_comb
    begin
        shift_next = shift_reg;
        bits_next  = bits_reg;
        gap_next   = gap_reg;
        code_next  = code_reg;
        latch      = 1'b0;
        if (!cmd_reg)
        begin
            priority if (is_bit)
            begin
                shift_next = {q_reg == irpwd_pkg::Q_ONE_BIT,
                              shift_reg[irpwd_pkg::SHIFT_W-1:1]};
                bits_next  = bits_reg + 1'b1;
                gap_next   = '0;
            end
            else if (abandon)
            begin
                bits_next = '0;
            end
            else
            begin
                gap_next = '0;
            end
            if (bits_next == irpwd_pkg::FRAME_BITS)
            begin
                code_next = shift_next;
                latch     = 1'b1;
            end
        end
        else
        begin
            gap_next = gap_inc;
            if (gap_inc > tmo_reg)
            begin
                bits_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= '0;
            bits_reg      <= '0;
            gap_reg       <= '0;
            code_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                shift_reg <= shift_next;
                bits_reg  <= bits_next;
                gap_reg   <= gap_next;
                code_reg  <= code_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {latch, code_next, bits_next, shift_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

`ifndef SYNTHESIS
    // quotient only arrives while a capture waits on it
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider done outside ST_DIV");

    // a latched code always comes with a full frame count
    a_latch_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[40]) |-> (out_data_reg[23:16] == irpwd_pkg::FRAME_BITS))
        else $error("code latched without full frame");

    // one update per item, then back to idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == ST_IDLE))
        else $error("update not followed by idle");

    // divider never restarted while busy
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");
`endif

endmodule
